>>> src/espic_pkg.sv
// Shared types, constants and saturation helpers for the encoder speed PI controller.
`default_nettype none
package espic_pkg;

  localparam int DATA_W   = 32;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 31;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_IN_W = 33;
  localparam int PROD_W   = 2 * MUL_IN_W;
  localparam int SAT_W    = 72;

  localparam logic [GAIN_W-1:0] TIME_STEP_RST = 16'd655;
  localparam logic [GAIN_W-1:0] STEP_RATE_RST = 16'd100;
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = 31'd65280;

  localparam logic [GAIN_W:0] FILT_OLD_WEIGHT = 17'd55706;
  localparam logic [GAIN_W:0] FILT_NEW_WEIGHT = 17'd9830;
  localparam logic signed [SAT_W-1:0] ROUND_HALF = 72'sd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INT_GAIN   = 3'd1,
    REG_TIME_STEP  = 3'd2,
    REG_STEP_RATE  = 3'd3,
    REG_DRIVE_LIM  = 3'd4,
    REG_INTEG_LIM  = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW,
    ST_FOLD,
    ST_FNEW,
    ST_PTERM,
    ST_KITS,
    ST_INC,
    ST_INTEG,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    MSEL_RAW,
    MSEL_FOLD,
    MSEL_FNEW,
    MSEL_PTERM,
    MSEL_KITS,
    MSEL_INC
  } mul_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     ld_raw;
    logic     ld_err;
    logic     ld_filt;
    logic     ld_p;
    logic     ld_integ;
    logic     ld_out;
  } ctrl_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = $signed({40'd0, 32'h7fffffff});
    lo = -hi - 72'sd1;
    if (x > hi) begin
      return hi[DATA_W-1:0];
    end else if (x < lo) begin
      return lo[DATA_W-1:0];
    end
    return x[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [SAT_W-1:0] x,
                                                         input logic [LIMIT_W-1:0] lim);
    logic signed [SAT_W-1:0] pos;
    logic signed [SAT_W-1:0] neg;
    pos = $signed({41'd0, lim});
    neg = -pos;
    if (x > pos) begin
      return pos[DATA_W-1:0];
    end else if (x < neg) begin
      return neg[DATA_W-1:0];
    end
    return x[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/espic_mul.sv
// Shared registered signed multiplier used by the multiply steps of the control update.
`default_nettype none
module espic_mul (
  input  wire logic                                clk,
  input  wire logic signed [espic_pkg::MUL_IN_W-1:0] a,
  input  wire logic signed [espic_pkg::MUL_IN_W-1:0] b,
  output logic signed [espic_pkg::PROD_W-1:0]      prod
);
  import espic_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
`default_nettype wire

>>> src/espic_seq.sv
// Sequencer that steps the shared multiplier through one control update.
`default_nettype none
module espic_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          opcode,
  input  wire logic          out_free,
  output logic               in_ready,
  output espic_pkg::ctrl_t   ctrl
);
  import espic_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    ctrl          = '0;
    ctrl.mul_sel  = MSEL_RAW;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = opcode ? ST_FINISH : ST_RAW;
        end
      end
      ST_RAW: begin
        ctrl.mul_sel = MSEL_RAW;
        state_next   = ST_FOLD;
      end
      ST_FOLD: begin
        ctrl.mul_sel = MSEL_FOLD;
        ctrl.ld_raw  = 1'b1;
        state_next   = ST_FNEW;
      end
      ST_FNEW: begin
        ctrl.mul_sel = MSEL_FNEW;
        ctrl.ld_err  = 1'b1;
        state_next   = ST_PTERM;
      end
      ST_PTERM: begin
        ctrl.mul_sel = MSEL_PTERM;
        ctrl.ld_filt = 1'b1;
        state_next   = ST_KITS;
      end
      ST_KITS: begin
        ctrl.mul_sel = MSEL_KITS;
        ctrl.ld_p    = 1'b1;
        state_next   = ST_INC;
      end
      ST_INC: begin
        ctrl.mul_sel = MSEL_INC;
        state_next   = ST_INTEG;
      end
      ST_INTEG: begin
        ctrl.ld_integ = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          ctrl.ld_out = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/encoder_speed_pi_controller_unit.sv
// Top level of the encoder speed PI controller: configuration, datapath and result register.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_ready    opcode, speed_setpoint, encoder_count
//   out       out_valid / out_ready  drive_out, measured_speed, smoothed_speed
//   cfg       cfg_write              cfg_index, cfg_data
//
// A compute request steps the sequencer through RAW, FOLD, FNEW, PTERM, KITS, INC, INTEG and FINISH,
// loads its result in FINISH, and the next request is taken back in IDLE; a clear request goes
// straight from IDLE to FINISH. The single shared multiplier is used six times per compute update.
// Reset restores the register defaults and clears the previous count, integrator and filter state.
// A result held in the output register does not block the next request; the update only waits in
// its final step if the previous result has not yet been taken.
`default_nettype none
module encoder_speed_pi_controller_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [espic_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [espic_pkg::LIMIT_W-1:0]          cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   opcode,
  input  wire logic signed [espic_pkg::DATA_W-1:0]    speed_setpoint,
  input  wire logic signed [espic_pkg::DATA_W-1:0]    encoder_count,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [espic_pkg::DATA_W-1:0]         drive_out,
  output logic signed [espic_pkg::DATA_W-1:0]         measured_speed,
  output logic signed [espic_pkg::DATA_W-1:0]         smoothed_speed
);
  import espic_pkg::*;

  logic [GAIN_W-1:0]  kp;
  logic [GAIN_W-1:0]  ki;
  logic [GAIN_W-1:0]  ts;
  logic [GAIN_W-1:0]  sr;
  logic [LIMIT_W-1:0] dlim;
  logic [LIMIT_W-1:0] ilim;

  logic [DATA_W-1:0]        prev;
  logic signed [DATA_W-1:0] integ;
  logic signed [DATA_W-1:0] filt;
  logic signed [DATA_W-1:0] diff;
  logic signed [DATA_W-1:0] target;
  logic                     op;
  logic signed [DATA_W-1:0] raw;
  logic signed [DATA_W-1:0] err;
  logic signed [DATA_W-1:0] p;
  logic signed [PROD_W-1:0] acc;

  logic signed [MUL_IN_W-1:0] mul_a;
  logic signed [MUL_IN_W-1:0] mul_b;
  logic signed [PROD_W-1:0]   prod;

  ctrl_t ctrl;
  logic  out_free;
  logic  accept;

  assign out_free = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  espic_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  espic_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      kp   <= '0;
      ki   <= '0;
      ts   <= TIME_STEP_RST;
      sr   <= STEP_RATE_RST;
      dlim <= LIMIT_RST;
      ilim <= LIMIT_RST;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_PROP_GAIN: kp   <= cfg_data[GAIN_W-1:0];
        REG_INT_GAIN:  ki   <= cfg_data[GAIN_W-1:0];
        REG_TIME_STEP: ts   <= cfg_data[GAIN_W-1:0];
        REG_STEP_RATE: sr   <= cfg_data[GAIN_W-1:0];
        REG_DRIVE_LIM: dlim <= cfg_data;
        REG_INTEG_LIM: ilim <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    mul_a = {diff[DATA_W-1], diff};
    mul_b = {17'd0, sr};
    case (ctrl.mul_sel)
      MSEL_RAW: begin
        mul_a = {diff[DATA_W-1], diff};
        mul_b = {17'd0, sr};
      end
      MSEL_FOLD: begin
        mul_a = {filt[DATA_W-1], filt};
        mul_b = {16'd0, FILT_OLD_WEIGHT};
      end
      MSEL_FNEW: begin
        mul_a = {raw[DATA_W-1], raw};
        mul_b = {16'd0, FILT_NEW_WEIGHT};
      end
      MSEL_PTERM: begin
        mul_a = {err[DATA_W-1], err};
        mul_b = {17'd0, kp};
      end
      MSEL_KITS: begin
        mul_a = {17'd0, ki};
        mul_b = {17'd0, ts};
      end
      MSEL_INC: begin
        mul_a = {err[DATA_W-1], err};
        mul_b = {1'b0, prod[DATA_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= opcode;
      target <= speed_setpoint;
      diff   <= encoder_count - prev;
    end
    if (ctrl.ld_raw) begin
      raw <= sat32(SAT_W'(prod) <<< 8);
    end
    if (ctrl.ld_err) begin
      acc <= prod;
      err <= sat32(SAT_W'(target) - SAT_W'(raw));
    end
    if (ctrl.ld_p) begin
      p <= sat32(SAT_W'(prod) >>> 8);
    end
    if (ctrl.ld_out) begin
      drive_out      <= op ? '0 : clamp_sym(SAT_W'(p) + SAT_W'(integ), dlim);
      measured_speed <= op ? '0 : raw;
      smoothed_speed <= filt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      integ     <= '0;
      filt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (opcode) begin
          prev  <= '0;
          integ <= '0;
        end else begin
          prev <= encoder_count;
        end
      end
      if (ctrl.ld_filt) begin
        filt <= sat32((SAT_W'(acc) + SAT_W'(prod) + ROUND_HALF) >>> 16);
      end
      if (ctrl.ld_integ) begin
        integ <= clamp_sym(SAT_W'(integ) + (SAT_W'(prod) >>> 24), ilim);
      end
      if (ctrl.ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("Request accepted while an update was still in progress.");

  a_clear_request: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode) |=> (integ == '0 && prev == '0))
    else $error("Clear request did not reset the integrator and previous count.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.ld_out |-> out_free)
    else $error("Result register loaded while holding an untaken result.");

  a_drive_in_limit: assert property (@(posedge clk) disable iff (rst)
    (ctrl.ld_out && !op) |=>
      ($signed({1'b0, dlim}) >= drive_out && -$signed({1'b0, dlim}) <= drive_out))
    else $error("Drive output exceeds the configured limit.");
`endif

endmodule
`default_nettype wire
